// ===== hw/rtl/t4swt_pkg.sv =====
package t4swt_pkg;

  localparam int unsigned MaxEntriesDef = 4;
  localparam int unsigned WeightW       = 16;
  localparam int unsigned JointW        = 16;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned OutCountW     = 3;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ERASE = 2'd1,
    OP_NORM  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_ERASED    = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_ZERO_SUM  = 3'd7
  } status_e;

  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;

endpackage

// ===== hw/rtl/t4swt_div.sv =====
module t4swt_div #(
  parameter int unsigned SumW = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [t4swt_pkg::WeightW-1:0] weight_i,
  input  logic [SumW-1:0]              sum_i,
  output logic [t4swt_pkg::WeightW-1:0] quotient_o,
  output t4swt_pkg::div_stat_t         stat_o
);
  import t4swt_pkg::*;

  localparam int unsigned NumW  = 2 * WeightW;
  localparam int unsigned StepW = $clog2(WeightW);

  logic [NumW-1:0]    num;
  logic [SumW-1:0]    rem_q, rem_d;
  logic [WeightW-1:0] nq_q, nq_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SumW:0]      shifted;
  logic [SumW+1:0]    diff;
  logic               ge;

  // weight * 65535 as (weight << 16) - weight
  assign num     = {weight_i, {WeightW{1'b0}}} - NumW'(weight_i);
  assign shifted = {rem_q, nq_q[WeightW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, sum_i};
  assign ge      = ~diff[SumW+1];

  always_comb begin
    rem_d  = rem_q;
    nq_d   = nq_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // upper quotient bits are zero since weight never exceeds the sum
      rem_d  = SumW'(num[NumW-1:WeightW]);
      nq_d   = num[WeightW-1:0];
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[SumW-1:0] : shifted[SumW-1:0];
      nq_d   = {nq_q[WeightW-2:0], ge};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(WeightW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
  end

  assign quotient_o  = nq_q;
  assign stat_o.done = done_q;
  assign stat_o.busy = busy_q;

endmodule

// ===== hw/rtl/top4_skin_weight_table.sv =====
// channel  dir  tdata (low bit up)                      tuser       tlast
// s_axis   in   joint_index[15:0] weight[31:16]         opcode[1:0] -
// m_axis   out  entry_joint[15:0] entry_weight[31:16]   status[2:0] last
//                entry_count[34:32] zero pad[39:35]
// one item at a time; s_axis_tready is high only while the sequencer is idle
// add with room appends; full add and erase scan n entries, may shift
// normalize sums the n entries, then divides each by the sum in the
// radix-2 divider that does one quotient bit a cycle (n entries held)
// results wait in an output register, which stalls the sequencer when full
// reset empties the table; entry contents are only read below the count
module top4_skin_weight_table #(
  parameter int unsigned MaxEntries = t4swt_pkg::MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // joint_index, weight
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // entry_joint, entry_weight, entry_count
  output logic [2:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);
  import t4swt_pkg::*;

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned SumW = WeightW + ((MaxEntries > 1) ? $clog2(MaxEntries) : 0);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  logic [JointW-1:0]  joint_mem [MaxEntries];
  logic [WeightW-1:0] weight_mem[MaxEntries];

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [JointW-1:0]  jnt_q, jnt_d;
  logic [WeightW-1:0] wgt_q, wgt_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    pos_q, pos_d;
  logic [WeightW-1:0] minw_q, minw_d;
  logic [SumW-1:0]    sum_q, sum_d;
  status_e            res_q, res_d;
  logic               start_q, start_d;

  logic               ov_q, ov_d;
  status_e            ostat_q, ostat_d;
  logic [JointW-1:0]  ojnt_q, ojnt_d;
  logic [WeightW-1:0] owgt_q, owgt_d;
  logic [OutCountW-1:0] ocnt_q, ocnt_d;
  logic               olast_q, olast_d;

  logic [CntW-1:0]    idx_inc;
  logic               idx_last;
  logic [CntW-1:0]    rd_idx;
  logic [JointW-1:0]  rd_j;
  logic [WeightW-1:0] rd_w;
  logic               j_we, w_we;
  logic [IdxW-1:0]    wr_idx;
  logic [JointW-1:0]  wr_j;
  logic [WeightW-1:0] wr_w;
  logic               out_free;
  logic [WeightW-1:0] div_quo;
  div_stat_t          div_stat;

  assign idx_inc  = idx_q + CntW'(1);
  assign idx_last = (idx_inc == cnt_q);
  assign rd_idx   = (state_q == S_SHIFT) ? idx_inc : idx_q;
  assign rd_j     = joint_mem[rd_idx[IdxW-1:0]];
  assign rd_w     = weight_mem[rd_idx[IdxW-1:0]];
  assign out_free = ~ov_q | m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  t4swt_div #(
    .SumW (SumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .weight_i   (rd_w),
    .sum_i      (sum_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    jnt_d   = jnt_q;
    wgt_d   = wgt_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    minw_d  = minw_q;
    sum_d   = sum_q;
    res_d   = res_q;
    start_d = 1'b0;
    j_we    = 1'b0;
    w_we    = 1'b0;
    wr_idx  = idx_q[IdxW-1:0];
    wr_j    = rd_j;
    wr_w    = rd_w;
    ov_d    = ov_q & ~m_axis_tready;
    ostat_d = ostat_q;
    ojnt_d  = ojnt_q;
    owgt_d  = owgt_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = op_e'(s_axis_tuser);
          jnt_d = s_axis_tdata[JointW-1:0];
          wgt_d = s_axis_tdata[JointW +: WeightW];
          idx_d = '0;
          pos_d = '0;
          sum_d = '0;
          case (op_e'(s_axis_tuser))
            OP_ADD: begin
              if (cnt_q < CntW'(MaxEntries)) begin
                j_we    = 1'b1;
                w_we    = 1'b1;
                wr_idx  = cnt_q[IdxW-1:0];
                wr_j    = s_axis_tdata[JointW-1:0];
                wr_w    = s_axis_tdata[JointW +: WeightW];
                cnt_d   = cnt_q + CntW'(1);
                res_d   = ST_APPENDED;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_ERASE: begin
              if (cnt_q == '0) begin
                res_d   = ST_NOT_FOUND;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_NORM: begin
              if (cnt_q == '0) begin
                res_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        case (op_q)
          OP_ADD: begin
            if (idx_q == '0 || rd_w < minw_q) begin
              minw_d = rd_w;
              pos_d  = idx_q[IdxW-1:0];
            end
            if (idx_last) state_d = S_DECIDE;
            else idx_d = idx_inc;
          end
          OP_ERASE: begin
            if (rd_j == jnt_q) begin
              state_d = S_SHIFT;
            end else if (idx_last) begin
              res_d   = ST_NOT_FOUND;
              state_d = S_RESP;
            end else begin
              idx_d = idx_inc;
            end
          end
          default: begin
            sum_d = sum_q + SumW'(rd_w);
            if (idx_last) state_d = S_DECIDE;
            else idx_d = idx_inc;
          end
        endcase
      end
      S_DECIDE: begin
        if (op_q == OP_ADD) begin
          if (wgt_q > minw_q) begin
            idx_d   = CntW'(pos_q);
            state_d = S_SHIFT;
          end else begin
            res_d   = ST_REJECTED;
            state_d = S_RESP;
          end
        end else if (sum_q == '0) begin
          res_d   = ST_ZERO_SUM;
          state_d = S_RESP;
        end else begin
          idx_d   = '0;
          start_d = 1'b1;
          state_d = S_DIV;
        end
      end
      S_SHIFT: begin
        if (idx_inc < cnt_q) begin
          // move the next entry down one place
          j_we  = 1'b1;
          w_we  = 1'b1;
          idx_d = idx_inc;
        end else if (op_q == OP_ADD) begin
          j_we    = 1'b1;
          w_we    = 1'b1;
          wr_j    = jnt_q;
          wr_w    = wgt_q;
          res_d   = ST_REPLACED;
          state_d = S_RESP;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          res_d   = ST_ERASED;
          state_d = S_RESP;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          w_we    = 1'b1;
          wr_w    = div_quo;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = ST_ENTRY;
          ojnt_d  = rd_j;
          owgt_d  = rd_w;
          ocnt_d  = OutCountW'(cnt_q);
          olast_d = idx_last;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            start_d = 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = res_q;
          ojnt_d  = '0;
          owgt_d  = '0;
          ocnt_d  = OutCountW'(cnt_q);
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      start_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    jnt_q   <= jnt_d;
    wgt_q   <= wgt_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    minw_q  <= minw_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    ostat_q <= ostat_d;
    ojnt_q  <= ojnt_d;
    owgt_q  <= owgt_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (j_we) joint_mem[wr_idx] <= wr_j;
    if (w_we) weight_mem[wr_idx] <= wr_w;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {5'b00000, ocnt_q, owgt_q, ojnt_q};
  assign m_axis_tlast  = olast_q;

endmodule

// ===== sim/t4swt_table_check.sv =====
`timescale 1ns / 1ps
module t4swt_table_check #(
  parameter int unsigned MaxEntries = t4swt_pkg::MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // joint_index, weight
  input  logic [1:0]  s_axis_tuser_i,   // opcode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // entry_joint, entry_weight, entry_count
  input  logic [2:0]  m_axis_tuser_i,   // status
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);
  import t4swt_pkg::*;

  typedef struct packed {
    status_e               status;
    logic [JointW-1:0]     joint;
    logic [WeightW-1:0]    weight;
    logic [OutCountW-1:0]  count;
    logic                  last;
  } table_reply_t;

  logic [JointW-1:0]  held_joint  [MaxEntries];
  logic [WeightW-1:0] held_weight [MaxEntries];
  int unsigned        held_n;
  table_reply_t       reply_q [$];
  int                 errs;

  function automatic void push_reply(status_e st, logic [JointW-1:0] jnt,
                                     logic [WeightW-1:0] wgt, logic lst);
    table_reply_t rep;
    rep = '{st, jnt, wgt, OutCountW'(held_n), lst};
    reply_q.insert(reply_q.size(), rep);
  endfunction

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < held_n; i++) begin
      held_joint[i]  = held_joint[i + 1];
      held_weight[i] = held_weight[i + 1];
    end
    held_n--;
  endfunction

  function automatic void apply_table_op(logic [1:0] op, logic [JointW-1:0] jnt,
                                         logic [WeightW-1:0] wgt);
    int unsigned pos;
    logic        hit;
    logic [63:0] total;
    logic [63:0] quot;
    pos   = 0;
    hit   = 1'b0;
    total = '0;
    case (op)
      OP_ADD: begin
        if (held_n < MaxEntries) begin
          held_joint[held_n]  = jnt;
          held_weight[held_n] = wgt;
          held_n++;
          push_reply(ST_APPENDED, '0, '0, 1'b1);
        end else begin
          // first smallest weight loses its place
          for (int unsigned i = 1; i < held_n; i++)
            if (held_weight[i] < held_weight[pos]) pos = i;
          if (wgt > held_weight[pos]) begin
            drop_entry(pos);
            held_joint[held_n]  = jnt;
            held_weight[held_n] = wgt;
            held_n++;
            push_reply(ST_REPLACED, '0, '0, 1'b1);
          end else begin
            push_reply(ST_REJECTED, '0, '0, 1'b1);
          end
        end
      end
      OP_ERASE: begin
        for (int unsigned i = 0; i < held_n && !hit; i++)
          if (held_joint[i] == jnt) begin
            hit = 1'b1;
            pos = i;
          end
        if (hit) begin
          drop_entry(pos);
          push_reply(ST_ERASED, '0, '0, 1'b1);
        end else begin
          push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      OP_NORM: begin
        for (int unsigned i = 0; i < held_n; i++) total += 64'(held_weight[i]);
        if (held_n == 0) begin
          push_reply(ST_EMPTY, '0, '0, 1'b1);
        end else if (total == 0) begin
          push_reply(ST_ZERO_SUM, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < held_n; i++) begin
            quot = (64'(held_weight[i]) * 64'd65535) / total;
            if (quot > 64'hFFFF) quot = 64'hFFFF;
            held_weight[i] = quot[WeightW-1:0];
            push_reply(ST_ENTRY, held_joint[i], held_weight[i], i + 1 == held_n);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_reply();
    table_reply_t want;
    if (reply_q.size() == 0) begin
      $error("item with nothing expected: status %0d", m_axis_tuser_i);
      errs++;
      return;
    end
    want = reply_q.pop_front();
    if (m_axis_tuser_i !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, m_axis_tuser_i);
      errs++;
    end
    if (m_axis_tdata_i[15:0] !== want.joint) begin
      $error("entry_joint: expected %0d, got %0d", want.joint, m_axis_tdata_i[15:0]);
      errs++;
    end
    if (m_axis_tdata_i[31:16] !== want.weight) begin
      $error("entry_weight: expected %0d, got %0d", want.weight, m_axis_tdata_i[31:16]);
      errs++;
    end
    if (m_axis_tdata_i[34:32] !== want.count) begin
      $error("entry_count: expected %0d, got %0d", want.count, m_axis_tdata_i[34:32]);
      errs++;
    end
    if (m_axis_tlast_i !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, m_axis_tlast_i);
      errs++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_n = 0;
      errs   = 0;
      reply_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_table_op(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]);
      if (m_axis_tvalid_i && m_axis_tready_i) check_reply();
      fail_count_o <= errs;
      pending_o    <= reply_q.size();
    end
  end

endmodule

// ===== sim/tb_top4_skin_weight_table.sv =====
`timescale 1ns / 1ps
module tb_top4_skin_weight_table;
  import t4swt_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned PhaseItems = 102;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // joint_index, weight
  logic [1:0]  s_axis_tuser  = '0;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // entry_joint, entry_weight, entry_count
  logic [2:0]  m_axis_tuser;         // status
  logic        m_axis_tlast;

  int unsigned tx_idle_pct = 8;
  int unsigned rx_idle_pct = 73;
  int          fail_count;
  int          pending;

  always #2 clk_i = ~clk_i;

  top4_skin_weight_table dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  t4swt_table_check u_table_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_op(input logic [1:0] op, input logic [15:0] jnt,
                         input logic [15:0] wgt);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wgt, jnt};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_table_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_joint();
    // mostly a few joints so that erase finds its target
    if ($urandom_range(99) < 70) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    if (r < 55) return 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned sent;
    logic [1:0]  op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table
    send_op(OP_NORM, 16'h0000, 16'h0000);
    send_op(OP_ERASE, 16'h1234, 16'h0000);
    // all weights zero
    send_op(OP_ADD, 16'h0000, 16'h0000);
    send_op(OP_ADD, 16'hFFFF, 16'h0000);
    send_op(OP_NORM, 16'hFFFF, 16'hFFFF);
    // fill, then reject an equal weight and replace the first minimum
    send_op(OP_ADD, 16'h0001, 16'hFFFF);
    send_op(OP_ADD, 16'h0002, 16'hFFFF);
    send_op(OP_ADD, 16'h0003, 16'h0000);
    send_op(OP_ADD, 16'h0004, 16'h0001);
    send_op(OP_NORM, 16'h0000, 16'h0000);
    send_op(OP_ERASE, 16'h0002, 16'hFFFF);
    send_op(OP_ERASE, 16'hFFFF, 16'h0000);
    send_op(OpUnused, 16'hFFFF, 16'hFFFF);
    send_op(OP_ERASE, 16'h1234, 16'h0000);
    send_op(OP_ERASE, 16'h0004, 16'h0000);
    // single entry scales to full range
    send_op(OP_NORM, 16'h0000, 16'h0000);
    send_op(OP_ADD, 16'h0005, 16'hFFFF);
    send_op(OP_ADD, 16'h0006, 16'hFFFF);
    send_op(OP_ADD, 16'h0007, 16'hFFFF);
    send_op(OP_ADD, 16'h0008, 16'hFFFF);
    send_op(OP_NORM, 16'h0000, 16'h0000);
    send_op(OP_ADD, 16'h0005, 16'h8000);
    send_op(OP_ERASE, 16'h0005, 16'h0000);
    wait_table_quiet();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 45) op = OP_ADD;
        else if (r < 70) op = OP_ERASE;
        else if (r < 93) op = OP_NORM;
        else op = OpUnused;
        send_op(op, pick_joint(), pick_weight());
        sent++;
      end
      wait_table_quiet();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/t4swt_pkg.sv
hw/rtl/t4swt_div.sv
hw/rtl/top4_skin_weight_table.sv
sim/t4swt_table_check.sv
sim/tb_top4_skin_weight_table.sv
